>>> src/mhbp_pkg.sv
// Shared types, constants and the per-round operation table for the
// mixing-hash block generator. No dependencies.
`default_nettype none

package mhbp_pkg;

    localparam int LANE_COUNT  = 4;
    localparam int LANE_W      = 64;
    localparam int HALF_W      = 32;
    localparam int BLOCK_BYTES = 32;
    localparam int WANT_W      = 6;
    localparam int COUNT_W     = 4;
    localparam int ROUNDS      = 8;

    // Operation slots in one round: byte injection, then three boxes of four steps
    localparam logic [3:0] LAST_OP  = 4'd12;
    // Last partial-product pass of the multiplier
    localparam logic [1:0] MUL_LAST = 2'd2;

    typedef logic [LANE_COUNT-1:0][LANE_W-1:0] t_lanes;

    typedef enum logic [1:0] {
        OP_XIN,
        OP_BOX1,
        OP_BOX2,
        OP_BOX3
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [1:0]  dst;
        logic [1:0]  src;
        logic [5:0]  shl;
        logic [5:0]  shr;
    } t_op;

    typedef struct packed {
        logic              start;
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
    } t_mul_req;

    // Decode one operation slot: destination accumulator, source accumulator, shifts
    function automatic t_op op_entry(input logic [3:0] op);
        t_op e;
        e = '{kind: OP_XIN, dst: 2'd0, src: 2'd0, shl: 6'd0, shr: 6'd0};
        case (op)
            4'd0:  e = '{kind: OP_XIN,  dst: 2'd0, src: 2'd0, shl: 6'd0,  shr: 6'd0};
            4'd1:  e = '{kind: OP_BOX1, dst: 2'd3, src: 2'd0, shl: 6'd32, shr: 6'd32};
            4'd2:  e = '{kind: OP_BOX1, dst: 2'd2, src: 2'd1, shl: 6'd24, shr: 6'd16};
            4'd3:  e = '{kind: OP_BOX1, dst: 2'd1, src: 2'd2, shl: 6'd32, shr: 6'd32};
            4'd4:  e = '{kind: OP_BOX1, dst: 2'd0, src: 2'd3, shl: 6'd16, shr: 6'd24};
            4'd5:  e = '{kind: OP_BOX2, dst: 2'd3, src: 2'd0, shl: 6'd32, shr: 6'd24};
            4'd6:  e = '{kind: OP_BOX2, dst: 2'd2, src: 2'd1, shl: 6'd24, shr: 6'd32};
            4'd7:  e = '{kind: OP_BOX2, dst: 2'd1, src: 2'd2, shl: 6'd32, shr: 6'd24};
            4'd8:  e = '{kind: OP_BOX2, dst: 2'd0, src: 2'd3, shl: 6'd24, shr: 6'd32};
            4'd9:  e = '{kind: OP_BOX3, dst: 2'd0, src: 2'd0, shl: 6'd0,  shr: 6'd0};
            4'd10: e = '{kind: OP_BOX3, dst: 2'd1, src: 2'd0, shl: 6'd0,  shr: 6'd0};
            4'd11: e = '{kind: OP_BOX3, dst: 2'd2, src: 2'd0, shl: 6'd0,  shr: 6'd0};
            4'd12: e = '{kind: OP_BOX3, dst: 2'd3, src: 2'd0, shl: 6'd0,  shr: 6'd0};
            default: e = '{kind: OP_XIN, dst: 2'd0, src: 2'd0, shl: 6'd0, shr: 6'd0};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

>>> src/mhbp_mul.sv
// Iterative 64x64 multiplier, low 64 bits of the product, built on one
// 32x32 multiplier used over three passes. Depends on mhbp_pkg.
`default_nettype none

module mhbp_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mhbp_pkg::t_mul_req         i_req,
    output logic                            o_done,
    output logic [mhbp_pkg::LANE_W-1:0]     o_prod
);

    logic                            r_busy;
    logic                            r_done;
    logic [1:0]                      r_step;
    logic [mhbp_pkg::LANE_W-1:0]     r_a;
    logic [mhbp_pkg::LANE_W-1:0]     r_b;
    logic [mhbp_pkg::LANE_W-1:0]     r_p;
    logic [mhbp_pkg::HALF_W-1:0]     r_m1;
    logic [mhbp_pkg::HALF_W-1:0]     r_m2;

    logic [mhbp_pkg::HALF_W-1:0]     w_x;
    logic [mhbp_pkg::HALF_W-1:0]     w_y;
    logic [mhbp_pkg::LANE_W-1:0]     w_pp;

    // Select the halves for this pass: lo*lo, lo*hi, hi*lo
    assign w_x  = (r_step == mhbp_pkg::MUL_LAST) ? r_a[63:32] : r_a[31:0];
    assign w_y  = (r_step == 2'd1) ? r_b[63:32] : r_b[31:0];
    assign w_pp = w_x * w_y;

    // Control: step through the passes after a start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= r_busy && (r_step == mhbp_pkg::MUL_LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == mhbp_pkg::MUL_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands and partial products
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            case (r_step)
                2'd0:    r_p  <= w_pp;
                2'd1:    r_m1 <= w_pp[31:0];
                default: r_m2 <= w_pp[31:0];
            endcase
        end
    end

    // Fold the cross terms into the upper half
    assign o_done = r_done;
    assign o_prod = {r_p[63:32] + r_m1 + r_m2, r_p[31:0]};

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_step == mhbp_pkg::MUL_LAST) |=> r_done)
        else $error("multiplier failed to signal completion");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("multiplier done while still busy");
`endif

endmodule

`default_nettype wire

>>> src/mhbp_core.sv
// Round sequencer and accumulators of the state rehash; drives the shared
// multiplier. Depends on mhbp_pkg.
`default_nettype none

module mhbp_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire mhbp_pkg::t_lanes           i_lanes,
    output logic                            o_done,
    output mhbp_pkg::t_lanes                o_acc,
    output mhbp_pkg::t_mul_req              o_mul_req,
    input  wire logic                       i_mul_done,
    input  wire logic [mhbp_pkg::LANE_W-1:0] i_mul_prod
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_MWAIT
    } t_state;

    t_state                        r_state;
    logic [3:0]                    r_op;
    logic [2:0]                    r_round;
    logic                          r_half;
    logic                          r_done;
    logic [mhbp_pkg::LANE_W-1:0]   r_p1;
    mhbp_pkg::t_lanes              r_acc;

    mhbp_pkg::t_op                 w_cur;
    logic [mhbp_pkg::LANE_W-1:0]   w_x;
    logic [mhbp_pkg::LANE_W-1:0]   w_y;
    logic [mhbp_pkg::LANE_W-1:0]   w_mix;
    logic [4:0]                    w_base;
    logic [mhbp_pkg::LANE_W-1:0]   w_src_lane;
    mhbp_pkg::t_lanes              w_xin;
    logic                          w_last;
    logic                          w_fin;
    logic                          w_adv;

    // Decode the current slot and form the shifted mix term
    assign w_cur  = mhbp_pkg::op_entry(r_op);
    assign w_x    = r_acc[w_cur.dst];
    assign w_y    = r_acc[w_cur.src];
    assign w_mix  = (w_y << w_cur.shl) ^ (w_x >> w_cur.shr);

    // Byte injection: four consecutive old-state bytes, placed at byte lane r
    assign w_base     = 5'd28 - {r_round, 2'b00};
    assign w_src_lane = i_lanes[w_base[4:3]];
    always_comb begin
        for (int i = 0; i < mhbp_pkg::LANE_COUNT; i++) begin
            w_xin[i] = {56'd0, w_src_lane[{w_base[2], 2'(i), 3'b000} +: 8]}
                       << {r_round, 3'b000};
        end
    end

    // Multiplier requests: box one multiplies mix by source, box three two products
    always_comb begin
        o_mul_req.start = ((r_state == S_ISSUE) &&
                           ((w_cur.kind == mhbp_pkg::OP_BOX1) ||
                            (w_cur.kind == mhbp_pkg::OP_BOX3))) ||
                          ((r_state == S_MWAIT) && i_mul_done &&
                           (w_cur.kind == mhbp_pkg::OP_BOX3) && !r_half);
        if (w_cur.kind == mhbp_pkg::OP_BOX1) begin
            o_mul_req.a = w_mix;
            o_mul_req.b = w_y;
        end else if (r_state == S_ISSUE) begin
            o_mul_req.a = r_acc[0];
            o_mul_req.b = r_acc[1];
        end else begin
            o_mul_req.a = r_acc[2];
            o_mul_req.b = r_acc[3];
        end
    end

    // Slot finished this cycle
    assign w_last = (r_op == mhbp_pkg::LAST_OP);
    assign w_fin  = w_last && (r_round == 3'(mhbp_pkg::ROUNDS - 1));
    assign w_adv  = ((r_state == S_ISSUE) &&
                     ((w_cur.kind == mhbp_pkg::OP_XIN) ||
                      (w_cur.kind == mhbp_pkg::OP_BOX2))) ||
                    ((r_state == S_MWAIT) && i_mul_done &&
                     ((w_cur.kind == mhbp_pkg::OP_BOX1) || r_half));

    // Sequencer state, accumulators and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= 4'd0;
            r_round <= 3'd0;
            r_half  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_op    <= 4'd0;
                        r_round <= 3'd0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    case (w_cur.kind)
                        mhbp_pkg::OP_XIN: begin
                            for (int i = 0; i < mhbp_pkg::LANE_COUNT; i++) begin
                                r_acc[i] <= r_acc[i] ^ w_xin[i];
                            end
                        end
                        mhbp_pkg::OP_BOX2: begin
                            r_acc[w_cur.dst] <= w_x ^ (w_mix + 64'd1);
                        end
                        default: begin
                            r_half  <= 1'b0;
                            r_state <= S_MWAIT;
                        end
                    endcase
                end
                S_MWAIT: begin
                    if (i_mul_done) begin
                        if (w_cur.kind == mhbp_pkg::OP_BOX1) begin
                            r_acc[w_cur.dst] <= w_x ^ (i_mul_prod + 64'd1);
                        end else if (!r_half) begin
                            r_p1   <= i_mul_prod;
                            r_half <= 1'b1;
                        end else begin
                            r_acc[w_cur.dst] <= w_x ^ ((r_p1 ^ i_mul_prod) + 64'd1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Advance to the next slot, the next round, or finish
            if (w_adv) begin
                if (w_fin) begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end else begin
                    r_op    <= w_last ? 4'd0 : r_op + 4'd1;
                    r_round <= w_last ? r_round + 3'd1 : r_round;
                    r_state <= S_ISSUE;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

>>> src/mixing_hash_block_prng_top.sv
// Top level of the mixing-hash block generator: request/result channels,
// seed register, state lanes. Depends on mhbp_pkg, mhbp_core, mhbp_mul.
`default_nettype none

// Each accepted request rehashes the 256-bit state and returns four
// transactions, lanes 0 to 3, each with the count of bytes the requester
// takes. The first request after reset loads the seed into lane 0 first; a
// seed written later has no effect, and reset clears the seed register. A
// request occupies the block through the hashing and then the output of the
// four lane words, one per transaction; o_in_stall is high throughout. The
// hashing time is set by the twelve 64-bit products per round, eight rounds,
// all through one 32x32 multiplier that takes three passes per product.
module mixing_hash_block_prng_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mhbp_pkg::LANE_W-1:0]   i_cfg_wr_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [mhbp_pkg::WANT_W-1:0]   i_bytes_wanted,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [1:0]                         o_word_index,
    output logic [mhbp_pkg::LANE_W-1:0]        o_word_value,
    output logic [mhbp_pkg::COUNT_W-1:0]       o_valid_bytes,
    output logic                               o_last_word
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_HASH,
        T_OUT
    } t_top_state;

    t_top_state                         r_state;
    logic                               r_seeded;
    logic [mhbp_pkg::LANE_W-1:0]        r_seed;
    mhbp_pkg::t_lanes                   r_lane;
    logic [mhbp_pkg::WANT_W-1:0]        r_want;
    logic [1:0]                         r_k;

    logic                               w_in_acc;
    logic                               w_out_acc;
    logic [mhbp_pkg::WANT_W-1:0]        w_want_sat;
    logic [mhbp_pkg::WANT_W-1:0]        w_word_start;
    logic [mhbp_pkg::WANT_W-1:0]        w_rem;
    logic                               w_core_done;
    mhbp_pkg::t_lanes                   w_acc;
    mhbp_pkg::t_mul_req                 w_mul_req;
    logic                               w_mul_done;
    logic [mhbp_pkg::LANE_W-1:0]        w_mul_prod;

    assign o_in_stall  = (r_state != T_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == T_OUT);
    assign w_out_acc   = o_out_valid && !i_out_stall;

    // Saturate the request to one block
    assign w_want_sat = (i_bytes_wanted > mhbp_pkg::WANT_W'(mhbp_pkg::BLOCK_BYTES))
                      ? mhbp_pkg::WANT_W'(mhbp_pkg::BLOCK_BYTES) : i_bytes_wanted;

    // Seed register, control state and lane storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_seeded <= 1'b0;
            r_seed   <= '0;
            r_k      <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            case (r_state)
                T_IDLE: begin
                    if (w_in_acc) begin
                        r_want <= w_want_sat;
                        if (!r_seeded) begin
                            r_lane   <= {{(mhbp_pkg::LANE_COUNT-1)*mhbp_pkg::LANE_W{1'b0}},
                                         r_seed};
                            r_seeded <= 1'b1;
                        end
                        r_state <= T_HASH;
                    end
                end
                T_HASH: begin
                    if (w_core_done) begin
                        r_lane  <= w_acc;
                        r_k     <= 2'd0;
                        r_state <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (w_out_acc) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_state <= T_IDLE;
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // Byte count for the word on offer: min(8, max(0, want - 8k))
    assign w_word_start = {1'b0, r_k, 3'b000};
    assign w_rem        = r_want - w_word_start;
    always_comb begin
        if (r_want <= w_word_start) begin
            o_valid_bytes = '0;
        end else if (w_rem > 6'd8) begin
            o_valid_bytes = 4'd8;
        end else begin
            o_valid_bytes = w_rem[3:0];
        end
    end

    assign o_word_index = r_k;
    assign o_word_value = r_lane[r_k];
    assign o_last_word  = (r_k == 2'd3);

    mhbp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_lanes    (r_lane),
        .o_done     (w_core_done),
        .o_acc      (w_acc),
        .o_mul_req  (w_mul_req),
        .i_mul_done (w_mul_done),
        .i_mul_prod (w_mul_prod)
    );

    mhbp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

`ifndef SYNTHESIS
    a_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_core_done |-> (r_state == T_HASH))
        else $error("hash completed outside the hash phase");
    a_seeded_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_seeded && (r_state == T_HASH))
        else $error("request accepted without seeding the state");
    a_want_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_OUT) |-> (r_want <= 6'd32) && (o_valid_bytes <= 4'd8))
        else $error("byte count out of range");
`endif

endmodule

`default_nettype wire
